/* rtl/core/stok_pkg.sv */
// Shared types, codes and keyword tables of the script token scanner.
`default_nettype none

package stok_pkg;

  localparam int POS_W      = 16;
  localparam int RES_MAX    = 4;
  localparam int SLOT_N     = 6;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_source;
  } in_word_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [15:0] token_offset;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic        last_of_run;
  } out_word_t;

  typedef enum logic [3:0] {
    M_IDLE    = 4'd0,
    M_LBRACE  = 4'd1,
    M_RBRACE  = 4'd2,
    M_MINUS   = 4'd3,
    M_AMP     = 4'd4,
    M_AMPDASH = 4'd5,
    M_STRING  = 4'd6,
    M_NUMBER  = 4'd7,
    M_NUMDOT  = 4'd8,
    M_FRAC    = 4'd9,
    M_IDENT   = 4'd10
  } scan_mode_t;

  localparam logic [4:0] TK_LPAREN   = 5'd0;
  localparam logic [4:0] TK_RPAREN   = 5'd1;
  localparam logic [4:0] TK_LBRACE   = 5'd2;
  localparam logic [4:0] TK_LBRACE2  = 5'd3;
  localparam logic [4:0] TK_RBRACE   = 5'd4;
  localparam logic [4:0] TK_RBRACE2  = 5'd5;
  localparam logic [4:0] TK_LBRACK   = 5'd6;
  localparam logic [4:0] TK_RBRACK   = 5'd7;
  localparam logic [4:0] TK_COLON    = 5'd8;
  localparam logic [4:0] TK_SEMI     = 5'd9;
  localparam logic [4:0] TK_COMMA    = 5'd10;
  localparam logic [4:0] TK_SYMBOL   = 5'd11;
  localparam logic [4:0] TK_ARROW    = 5'd12;
  localparam logic [4:0] TK_MINUS    = 5'd13;
  localparam logic [4:0] TK_AMPARROW = 5'd14;
  localparam logic [4:0] TK_STRING   = 5'd15;
  localparam logic [4:0] TK_NUMBER   = 5'd16;
  localparam logic [4:0] TK_IDENT    = 5'd17;
  localparam logic [4:0] TK_LISTEN   = 5'd18;
  localparam logic [4:0] TK_DELEGATE = 5'd19;
  localparam logic [4:0] TK_ANIMATE  = 5'd20;
  localparam logic [4:0] TK_END      = 5'd21;

  localparam logic [15:0] LINE_MAX   = 16'hFFFF;
  localparam logic [15:0] LINE_RESET = 16'd1;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  // Keyword text lengths: Listen, Delegate, Animate
  localparam logic [3:0] KW_LEN0 = 4'd6;
  localparam logic [3:0] KW_LEN1 = 4'd8;
  localparam logic [3:0] KW_LEN2 = 4'd7;

  function automatic logic [3:0] kw_len(input logic [1:0] k);
    case (k)
      2'd0:    kw_len = KW_LEN0;
      2'd1:    kw_len = KW_LEN1;
      default: kw_len = KW_LEN2;
    endcase
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] i);
    logic [63:0] txt;
    case (k)
      2'd0:    txt = {16'h0000, "nets", "iL"};
      2'd1:    txt = "etageleD";
      default: txt = {8'h00, "etaminA"};
    endcase
    kw_char = txt[8*i +: 8];
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    is_alpha = ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  endfunction

  // Drop each keyword whose text does not hold c at index idx.
  function automatic logic [2:0] mask_upd(input logic [2:0] m, input logic [7:0] c,
                                          input pos_t idx);
    logic [2:0] r;
    r = m;
    for (int k = 0; k < 3; k++) begin
      if ((idx >= pos_t'(kw_len(2'(k)))) || (kw_char(2'(k), idx[2:0]) != c)) begin
        r[k] = 1'b0;
      end
    end
    mask_upd = r;
  endfunction

  function automatic logic [4:0] ident_kind(input logic [2:0] m, input pos_t len);
    logic [4:0] r;
    r = TK_IDENT;
    if (m[0] && (len == pos_t'(KW_LEN0))) r = TK_LISTEN;
    if (m[1] && (len == pos_t'(KW_LEN1))) r = TK_DELEGATE;
    if (m[2] && (len == pos_t'(KW_LEN2))) r = TK_ANIMATE;
    ident_kind = r;
  endfunction

  function automatic out_word_t mk_tok(input logic [4:0] kind, input pos_t off,
                                       input pos_t len, input logic [15:0] line);
    out_word_t w;
    w.token_kind   = kind;
    w.token_offset = 16'(off);
    w.token_length = 16'(len);
    w.line_number  = line;
    w.last_of_run  = 1'b0;
    mk_tok = w;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/script_token_scanner.sv */
// Top level of the script token scanner: input register, scan core, result queue.
//
//  channel | direction | handshake      | word
//  --------+-----------+----------------+------------------------------------------
//  in_     | in        | valid / stall  | in_word_t  : char_byte, end_of_source
//  out_    | out       | valid / stall  | out_word_t : kind, offset, length, line, last
//  cfg_    | in        | valid / ready  | first_line_number, 16 bits
//
// One source byte is taken per cycle; each byte is evaluated from the input register
// once the queue has room and yields zero to four tokens into an 8-entry queue.
// Tokens leave at one per cycle, so bytes flow at full rate while each averages at
// most one token; the queue's free space (four entries) sets when in_stall rises.
// Reset (rst_n low, synchronous) empties the queue and the input register, sets the
// first line number to 1 and rewinds position, line and mode.
// A stalled output keeps its word; the input keeps accepting until fewer than four
// queue entries are free.
`default_nettype none

module script_token_scanner
  import stok_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_word_t    in_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_word_t        out_word,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_first_line_number
);

  logic      in_vld_r;
  in_word_t  in_word_r;
  logic      room;
  logic      take;
  out_word_t res [RES_MAX];
  logic [2:0] res_cnt;

  // Evaluate the held byte whenever the queue can absorb a worst-case burst.
  assign take      = in_vld_r && room;
  assign in_stall  = in_vld_r && !room;
  assign cfg_ready = 1'b1;

  // Input register: load a new word whenever the held one moves on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_word_r <= in_word;
    end
  end

  stok_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .word     (in_word_r),
    .cfg_wr   (cfg_valid && cfg_ready),
    .cfg_data (cfg_first_line_number),
    .res      (res),
    .res_cnt  (res_cnt)
  );

  // Drain tokens in order, one per accepted output word.
  stok_res_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (take),
    .wr_data  (res),
    .wr_cnt   (res_cnt),
    .room     (room),
    .rd_valid (out_valid),
    .rd_data  (out_word),
    .pop      (out_valid && !out_stall)
  );

endmodule

`default_nettype wire

/* rtl/core/stok_scan.sv */
// Scanner state registers and the single-pass byte evaluation.
`default_nettype none

module stok_scan
  import stok_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        take,
  input  wire in_word_t    word,
  input  wire logic        cfg_wr,
  input  wire logic [15:0] cfg_data,
  output out_word_t        res [RES_MAX],
  output logic [2:0]       res_cnt
);

  logic [15:0] first_line_r;
  pos_t        pos_r, pos_nxt;
  logic [15:0] line_r, line_nxt;
  pos_t        start_r, start_nxt;
  scan_mode_t  mode_r, mode_nxt;
  logic        quote_r, quote_nxt;
  logic [2:0]  mask_r, mask_nxt;

  out_word_t   slot [SLOT_N];
  logic [SLOT_N-1:0] slot_v;

  logic [7:0]  c;
  logic        go_idle;
  logic [15:0] line_mid;
  pos_t        p, pos_inc, rel;
  logic [7:0]  quote_ch;
  logic [2:0]  n;
  logic [2:0]  n_m1;

  assign c        = word.char_byte;
  assign p        = pos_r;
  assign rel      = pos_r - start_r;
  assign pos_inc  = (pos_r != '1) ? pos_r + pos_t'(1) : pos_r;
  assign quote_ch = quote_r ? 8'h27 : 8'h22;

  // Slots in emit order: 0,1 pending token; 2 fresh token; 3,4 flush; 5 end.
  always_comb begin
    mode_nxt  = mode_r;
    start_nxt = start_r;
    quote_nxt = quote_r;
    mask_nxt  = mask_r;
    line_mid  = line_r;
    pos_nxt   = pos_inc;
    go_idle   = 1'b0;
    slot_v    = '0;
    for (int i = 0; i < SLOT_N; i++) begin
      slot[i] = '0;
    end

    case (mode_r)
      M_LBRACE: begin
        if (c == "{") begin
          slot[0] = mk_tok(TK_LBRACE2, start_r, pos_t'(2), line_r);
          mode_nxt = M_IDLE;
        end else begin
          slot[0] = mk_tok(TK_LBRACE, start_r, pos_t'(1), line_r);
          go_idle = 1'b1;
        end
        slot_v[0] = 1'b1;
      end
      M_RBRACE: begin
        if (c == "}") begin
          slot[0] = mk_tok(TK_RBRACE2, start_r, pos_t'(2), line_r);
          mode_nxt = M_IDLE;
        end else begin
          slot[0] = mk_tok(TK_RBRACE, start_r, pos_t'(1), line_r);
          go_idle = 1'b1;
        end
        slot_v[0] = 1'b1;
      end
      M_MINUS: begin
        if (c == ">") begin
          slot[0] = mk_tok(TK_ARROW, start_r, pos_t'(2), line_r);
          mode_nxt = M_IDLE;
        end else begin
          slot[0] = mk_tok(TK_MINUS, start_r, pos_t'(1), line_r);
          go_idle = 1'b1;
        end
        slot_v[0] = 1'b1;
      end
      M_AMP: begin
        if (c == "-") mode_nxt = M_AMPDASH;
        else go_idle = 1'b1;
      end
      M_AMPDASH: begin
        if (c == ">") begin
          slot[0]   = mk_tok(TK_AMPARROW, start_r, pos_t'(3), line_r);
          slot_v[0] = 1'b1;
          mode_nxt  = M_IDLE;
        end else begin
          go_idle = 1'b1;
        end
      end
      M_STRING: begin
        if (c == quote_ch) begin
          slot[0]   = mk_tok(TK_STRING, start_r + pos_t'(1), rel - pos_t'(1), line_r);
          slot_v[0] = 1'b1;
          mode_nxt  = M_IDLE;
        end else if (c == CH_NL) begin
          line_mid = (line_r != LINE_MAX) ? line_r + 16'd1 : line_r;
        end
      end
      M_NUMBER: begin
        if (c == ".") begin
          mode_nxt = M_NUMDOT;
        end else if (!is_digit(c)) begin
          slot[0]   = mk_tok(TK_NUMBER, start_r, rel, line_r);
          slot_v[0] = 1'b1;
          go_idle   = 1'b1;
        end
      end
      M_NUMDOT: begin
        if (is_digit(c)) begin
          mode_nxt = M_FRAC;
        end else begin
          slot[0]  = mk_tok(TK_NUMBER, start_r, rel - pos_t'(1), line_r);
          slot[1]  = mk_tok(TK_SYMBOL, p - pos_t'(1), pos_t'(1), line_r);
          slot_v[1:0] = 2'b11;
          go_idle  = 1'b1;
        end
      end
      M_FRAC: begin
        if (!is_digit(c)) begin
          slot[0]   = mk_tok(TK_NUMBER, start_r, rel, line_r);
          slot_v[0] = 1'b1;
          go_idle   = 1'b1;
        end
      end
      M_IDENT: begin
        if (is_alpha(c) || is_digit(c) || (c == CH_UNDER)) begin
          mask_nxt = mask_upd(mask_r, c, rel);
        end else begin
          slot[0]   = mk_tok(ident_kind(mask_r, rel), start_r, rel, line_r);
          slot_v[0] = 1'b1;
          go_idle   = 1'b1;
        end
      end
      default: begin
        go_idle = 1'b1;
      end
    endcase

    // Start a fresh token at this byte.
    if (go_idle) begin
      start_nxt = p;
      mode_nxt  = M_IDLE;
      slot[2]   = mk_tok(TK_SYMBOL, p, pos_t'(1), line_r);
      case (c)
        "(":  begin slot[2].token_kind = TK_LPAREN; slot_v[2] = 1'b1; end
        ")":  begin slot[2].token_kind = TK_RPAREN; slot_v[2] = 1'b1; end
        "[":  begin slot[2].token_kind = TK_LBRACK; slot_v[2] = 1'b1; end
        "]":  begin slot[2].token_kind = TK_RBRACK; slot_v[2] = 1'b1; end
        ":":  begin slot[2].token_kind = TK_COLON;  slot_v[2] = 1'b1; end
        ";":  begin slot[2].token_kind = TK_SEMI;   slot_v[2] = 1'b1; end
        ",":  begin slot[2].token_kind = TK_COMMA;  slot_v[2] = 1'b1; end
        ".", "#": slot_v[2] = 1'b1;
        "{":  mode_nxt = M_LBRACE;
        "}":  mode_nxt = M_RBRACE;
        "-":  mode_nxt = M_MINUS;
        "&":  mode_nxt = M_AMP;
        CH_NL: line_mid = (line_r != LINE_MAX) ? line_r + 16'd1 : line_r;
        8'h22: begin mode_nxt = M_STRING; quote_nxt = 1'b0; end
        8'h27: begin mode_nxt = M_STRING; quote_nxt = 1'b1; end
        default: begin
          if (is_digit(c)) begin
            mode_nxt = M_NUMBER;
          end else if (is_alpha(c) || (c == CH_UNDER)) begin
            mode_nxt = M_IDENT;
            mask_nxt = mask_upd(3'b111, c, '0);
          end
        end
      endcase
    end

    line_nxt = line_mid;

    // Last byte: flush the open token, add the end token, rewind.
    if (word.end_of_source) begin
      case (mode_nxt)
        M_LBRACE: begin
          slot[3] = mk_tok(TK_LBRACE, start_nxt, pos_t'(1), line_mid); slot_v[3] = 1'b1;
        end
        M_RBRACE: begin
          slot[3] = mk_tok(TK_RBRACE, start_nxt, pos_t'(1), line_mid); slot_v[3] = 1'b1;
        end
        M_MINUS: begin
          slot[3] = mk_tok(TK_MINUS, start_nxt, pos_t'(1), line_mid); slot_v[3] = 1'b1;
        end
        M_NUMBER, M_FRAC: begin
          slot[3]   = mk_tok(TK_NUMBER, start_nxt, pos_inc - start_nxt, line_mid);
          slot_v[3] = 1'b1;
        end
        M_NUMDOT: begin
          slot[3] = mk_tok(TK_NUMBER, start_nxt, pos_inc - pos_t'(1) - start_nxt, line_mid);
          slot[4] = mk_tok(TK_SYMBOL, pos_inc - pos_t'(1), pos_t'(1), line_mid);
          slot_v[4:3] = 2'b11;
        end
        M_IDENT: begin
          slot[3] = mk_tok(ident_kind(mask_nxt, pos_inc - start_nxt), start_nxt,
                           pos_inc - start_nxt, line_mid);
          slot_v[3] = 1'b1;
        end
        default: begin
        end
      endcase
      slot[5]   = mk_tok(TK_END, pos_inc, '0, line_mid);
      slot_v[5] = 1'b1;
      pos_nxt   = '0;
      line_nxt  = first_line_r;
      start_nxt = '0;
      mode_nxt  = M_IDLE;
      quote_nxt = 1'b0;
      mask_nxt  = 3'b111;
    end
  end

  // Pack the live slots to the front and mark the final one.
  always_comb begin
    for (int i = 0; i < RES_MAX; i++) begin
      res[i] = '0;
    end
    n = '0;
    for (int i = 0; i < SLOT_N; i++) begin
      if (slot_v[i]) begin
        res[n[1:0]] = slot[i];
        n = n + 3'd1;
      end
    end
    n_m1 = n - 3'd1;
    if (n != 3'd0) res[n_m1[1:0]].last_of_run = 1'b1;
  end

  assign res_cnt = n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_line_r <= LINE_RESET;
      pos_r        <= '0;
      line_r       <= LINE_RESET;
      start_r      <= '0;
      mode_r       <= M_IDLE;
      quote_r      <= 1'b0;
      mask_r       <= 3'b111;
    end else begin
      if (cfg_wr) begin
        first_line_r <= cfg_data;
      end
      if (take) begin
        pos_r   <= pos_nxt;
        line_r  <= line_nxt;
        start_r <= start_nxt;
        mode_r  <= mode_nxt;
        quote_r <= quote_nxt;
        mask_r  <= mask_nxt;
      end else if (cfg_wr && (pos_r == '0)) begin
        line_r <= cfg_data;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/stok_res_fifo.sv */
// Result queue: takes up to four tokens a cycle, hands out one a cycle.
`default_nettype none

module stok_res_fifo
  import stok_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire out_word_t wr_data [RES_MAX],
  input  wire logic [2:0] wr_cnt,
  output logic           room,
  output logic           rd_valid,
  output out_word_t      rd_data,
  input  wire logic      pop
);

  out_word_t           mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wp_r, rp_r;
  logic [FIFO_AW:0]    cnt_r;
  logic [2:0]          add;

  assign add      = push ? wr_cnt : 3'd0;
  assign room     = cnt_r <= (FIFO_AW+1)'(FIFO_DEPTH - RES_MAX);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    for (int i = 0; i < RES_MAX; i++) begin
      if (push && (3'(i) < wr_cnt)) begin
        mem_r[wp_r + FIFO_AW'(i)] <= wr_data[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + FIFO_AW'(add);
      if (pop) rp_r <= rp_r + FIFO_AW'(1);
      cnt_r <= cnt_r + (FIFO_AW+1)'(add) - (FIFO_AW+1)'(pop);
    end
  end

endmodule

`default_nettype wire

/* rtl/core/stok_checker.sv */
// Port-level checks of the script token scanner and their bind.
`default_nettype none

module stok_checker
  import stok_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire in_word_t    in_word,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire out_word_t   out_word
);

  // Hold a stalled output word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

  // Hold a stalled input word on the sending side.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_word))
    else $error("stalled input word changed");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.token_kind == TK_END) |->
      out_word.last_of_run && (out_word.token_length == 16'd0))
    else $error("end token not last or not empty");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.token_kind <= TK_END)
    else $error("token kind out of range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output valid or input stalled after reset");

endmodule

bind script_token_scanner stok_checker u_stok_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

`default_nettype wire

/* bench/script_token_scanner_checker.sv */
// Checker for the script token scanner: tracks the scanner state, predicts tokens, compares words.
`timescale 1ns / 100ps

module script_token_scanner_checker
  import stok_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_word_t    in_word,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_word_t   out_word,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_first_line_number,
  output int          fail_count,
  output int          tokens_pending
);

  localparam logic [7:0] CH_SQUOTE = "'";
  localparam logic [7:0] CH_DQUOTE = "\"";
  localparam pos_t       POS_TOP   = '1;

  logic [15:0] first_line;
  logic [15:0] line_cnt;
  pos_t        pos;
  pos_t        tok_start;
  scan_mode_t  mode;
  logic        quote_single;
  logic [2:0]  kw_mask;
  out_word_t   tokens_due[$];
  out_word_t   byte_tokens[$];
  int          errs = 0;

  function automatic int keyword_len(input int k);
    case (k)
      0:       return 6;
      1:       return 8;
      default: return 7;
    endcase
  endfunction

  function automatic logic [7:0] keyword_char(input int k, input int i);
    logic [63:0] text;
    case (k)
      0:       text = 64'("Listen");
      1:       text = 64'("Delegate");
      default: text = 64'("Animate");
    endcase
    return text[8*(keyword_len(k)-1-i) +: 8];
  endfunction

  function automatic logic is_numeral(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  endfunction

  task automatic add_token(input logic [4:0] kind, input pos_t off, input pos_t len);
    out_word_t w;
    if (byte_tokens.size() < RES_MAX) begin
      w.token_kind   = kind;
      w.token_offset = 16'(off);
      w.token_length = 16'(len);
      w.line_number  = line_cnt;
      w.last_of_run  = 1'b0;
      byte_tokens    = {byte_tokens, w};
    end
  endtask

  task automatic bump_line();
    if (line_cnt != LINE_MAX) line_cnt = line_cnt + 16'd1;
  endtask

  // Drop every keyword that cannot hold c at this index.
  task automatic narrow_keywords(input logic [7:0] c, input pos_t idx);
    for (int k = 0; k < 3; k++) begin
      if (idx >= pos_t'(keyword_len(k))) begin
        kw_mask[k] = 1'b0;
      end else if (keyword_char(k, int'(idx)) != c) begin
        kw_mask[k] = 1'b0;
      end
    end
  endtask

  task automatic close_ident(input pos_t stop);
    pos_t       len;
    logic [4:0] kind;
    len  = stop - tok_start;
    kind = TK_IDENT;
    if (kw_mask[0] && (len == pos_t'(keyword_len(0)))) kind = TK_LISTEN;
    if (kw_mask[1] && (len == pos_t'(keyword_len(1)))) kind = TK_DELEGATE;
    if (kw_mask[2] && (len == pos_t'(keyword_len(2)))) kind = TK_ANIMATE;
    add_token(kind, tok_start, len);
  endtask

  task automatic open_token(input logic [7:0] c, input pos_t p);
    tok_start = p;
    mode      = M_IDLE;
    case (c)
      "(":       add_token(TK_LPAREN, p, 1);
      ")":       add_token(TK_RPAREN, p, 1);
      "[":       add_token(TK_LBRACK, p, 1);
      "]":       add_token(TK_RBRACK, p, 1);
      ":":       add_token(TK_COLON, p, 1);
      ";":       add_token(TK_SEMI, p, 1);
      ",":       add_token(TK_COMMA, p, 1);
      ".", "#":  add_token(TK_SYMBOL, p, 1);
      "{":       mode = M_LBRACE;
      "}":       mode = M_RBRACE;
      "-":       mode = M_MINUS;
      "&":       mode = M_AMP;
      CH_NL:     bump_line();
      CH_DQUOTE: begin
        mode         = M_STRING;
        quote_single = 1'b0;
      end
      CH_SQUOTE: begin
        mode         = M_STRING;
        quote_single = 1'b1;
      end
      default: begin
        if (is_numeral(c)) begin
          mode = M_NUMBER;
        end else if (is_letter(c) || (c == CH_UNDER)) begin
          mode    = M_IDENT;
          kw_mask = 3'b111;
          narrow_keywords(c, '0);
        end
      end
    endcase
  endtask

  // Feed one byte to the pending token; start a new one unless the byte was absorbed.
  task automatic take_byte(input logic [7:0] c, input pos_t p);
    logic       absorbed;
    logic [7:0] closer;
    absorbed = 1'b0;
    closer   = quote_single ? CH_SQUOTE : CH_DQUOTE;
    case (mode)
      M_LBRACE: begin
        if (c == "{") begin
          add_token(TK_LBRACE2, tok_start, 2);
          mode     = M_IDLE;
          absorbed = 1'b1;
        end else add_token(TK_LBRACE, tok_start, 1);
      end
      M_RBRACE: begin
        if (c == "}") begin
          add_token(TK_RBRACE2, tok_start, 2);
          mode     = M_IDLE;
          absorbed = 1'b1;
        end else add_token(TK_RBRACE, tok_start, 1);
      end
      M_MINUS: begin
        if (c == ">") begin
          add_token(TK_ARROW, tok_start, 2);
          mode     = M_IDLE;
          absorbed = 1'b1;
        end else add_token(TK_MINUS, tok_start, 1);
      end
      M_AMP: begin
        if (c == "-") begin
          mode     = M_AMPDASH;
          absorbed = 1'b1;
        end
      end
      M_AMPDASH: begin
        if (c == ">") begin
          add_token(TK_AMPARROW, tok_start, 3);
          mode     = M_IDLE;
          absorbed = 1'b1;
        end
      end
      M_STRING: begin
        absorbed = 1'b1;
        if (c == closer) begin
          add_token(TK_STRING, tok_start + pos_t'(1), p - tok_start - pos_t'(1));
          mode = M_IDLE;
        end else if (c == CH_NL) begin
          bump_line();
        end
      end
      M_NUMBER: begin
        if (is_numeral(c)) begin
          absorbed = 1'b1;
        end else if (c == ".") begin
          mode     = M_NUMDOT;
          absorbed = 1'b1;
        end else add_token(TK_NUMBER, tok_start, p - tok_start);
      end
      M_NUMDOT: begin
        if (is_numeral(c)) begin
          mode     = M_FRAC;
          absorbed = 1'b1;
        end else begin
          add_token(TK_NUMBER, tok_start, p - pos_t'(1) - tok_start);
          add_token(TK_SYMBOL, p - pos_t'(1), 1);
        end
      end
      M_FRAC: begin
        if (is_numeral(c)) absorbed = 1'b1;
        else add_token(TK_NUMBER, tok_start, p - tok_start);
      end
      M_IDENT: begin
        if (is_letter(c) || is_numeral(c) || (c == CH_UNDER)) begin
          narrow_keywords(c, p - tok_start);
          absorbed = 1'b1;
        end else close_ident(p);
      end
      default: ;
    endcase
    if (!absorbed) open_token(c, p);
  endtask

  task automatic flush_pending(input pos_t stop);
    case (mode)
      M_LBRACE:         add_token(TK_LBRACE, tok_start, 1);
      M_RBRACE:         add_token(TK_RBRACE, tok_start, 1);
      M_MINUS:          add_token(TK_MINUS, tok_start, 1);
      M_NUMBER, M_FRAC: add_token(TK_NUMBER, tok_start, stop - tok_start);
      M_NUMDOT: begin
        add_token(TK_NUMBER, tok_start, stop - pos_t'(1) - tok_start);
        add_token(TK_SYMBOL, stop - pos_t'(1), 1);
      end
      M_IDENT:          close_ident(stop);
      default: ;
    endcase
  endtask

  task automatic restart_source();
    pos          = '0;
    line_cnt     = first_line;
    tok_start    = '0;
    mode         = M_IDLE;
    quote_single = 1'b0;
    kw_mask      = 3'b111;
  endtask

  task automatic scan_predict(input logic [7:0] c, input logic eos);
    pos_t      p;
    out_word_t w;
    p = pos;
    byte_tokens.delete();
    take_byte(c, p);
    if (pos != POS_TOP) pos = pos + 1'b1;
    if (eos) begin
      flush_pending(pos);
      add_token(TK_END, pos, 0);
      restart_source();
    end
    if (byte_tokens.size() > 0) begin
      w                                   = byte_tokens[byte_tokens.size() - 1];
      w.last_of_run                       = 1'b1;
      byte_tokens[byte_tokens.size() - 1] = w;
    end
    foreach (byte_tokens[i]) tokens_due = {tokens_due, byte_tokens[i]};
    byte_tokens.delete();
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      first_line = LINE_RESET;
      restart_source();
      tokens_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        first_line = cfg_first_line_number;
        if (pos == '0) line_cnt = cfg_first_line_number;
      end
      if (in_valid && !in_stall) scan_predict(in_word.char_byte, in_word.end_of_source);
      if (out_valid && !out_stall) begin
        if (tokens_due.size() == 0) begin
          $error("token kind %0d at offset %0d arrived with none expected",
                 out_word.token_kind, out_word.token_offset);
          errs++;
        end else begin
          want = tokens_due.pop_front();
          check_field("token_kind", 16'(want.token_kind), 16'(out_word.token_kind));
          check_field("token_offset", want.token_offset, out_word.token_offset);
          check_field("token_length", want.token_length, out_word.token_length);
          check_field("line_number", want.line_number, out_word.line_number);
          check_field("last_of_run", 16'(want.last_of_run), 16'(out_word.last_of_run));
        end
      end
    end
    fail_count     <= errs;
    tokens_pending <= tokens_due.size();
  end

endmodule

/* bench/tb_script_token_scanner.sv */
// Testbench top for the script token scanner: clock, reset, byte stimulus, token sink, verdict.
`timescale 1ns / 100ps

module tb_script_token_scanner;
  import stok_pkg::*;

  // Longest legal quiet spell is the one long receiver hold-off plus a few gaps.
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int DRAIN_CYCLES    = 10;
  localparam int HOLD_OFF_CYCLES = 300;
  // byte budget of the whole run, directed sources included
  localparam int RANDOM_ITEMS    = 460;
  localparam int PHASES          = 6;
  localparam int GAP_MAX         = 12;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_word;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_word;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_first_line_number;

  int         fail_count;
  int         tokens_pending;
  int         idle_cycles = 0;
  int         tx_gap_max  = GAP_MAX;
  int         rx_gap_max  = GAP_MAX;
  bit         want_hold_off;
  logic [7:0] src_text[$];
  int         sent_bytes = 0;

  script_token_scanner dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_word              (in_word),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_word             (out_word),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_first_line_number(cfg_first_line_number)
  );

  script_token_scanner_checker u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_word              (in_word),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_word             (out_word),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_first_line_number(cfg_first_line_number),
    .fail_count           (fail_count),
    .tokens_pending       (tokens_pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Count cycles in which no word moves on any channel; give up past the limit.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("script_token_scanner verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Token sink: draw a stall for every word, then take it. Once during the run,
  // hold off for a long stretch so the result queue fills and in_stall rises.
  initial begin : token_sink
    int stall_n;
    bit hold_done;
    forever begin
      if (want_hold_off && !hold_done) begin
        stall_n   = HOLD_OFF_CYCLES;
        hold_done = 1'b1;
      end else begin
        stall_n = (rx_gap_max == 0) ? 0 : $urandom_range(0, rx_gap_max);
      end
      if (stall_n > 0) begin
        out_stall <= 1'b1;
        repeat (stall_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Offer one byte after a random gap and hold it until the scanner takes it.
  task automatic send_byte(input logic [7:0] c, input logic eos);
    int gap;
    gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= {c, eos};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_bytes++;
  endtask

  // Drain the staged text; mark the last byte as end of source when asked.
  task automatic send_text(input logic close_source);
    logic [7:0] c;
    while (src_text.size() > 0) begin
      c = src_text.pop_front();
      send_byte(c, close_source && (src_text.size() == 0));
    end
  endtask

  task automatic stage_char(input logic [7:0] c);
    src_text = {src_text, c};
  endtask

  task automatic load_text(input string s);
    for (int i = 0; i < s.len(); i++) stage_char(s[i]);
  endtask

  function automatic logic [7:0] pick_char(input string pool);
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  // Drop valid, wait for every expected token, then give the pipeline time to go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tokens_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_first_line(input logic [15:0] value);
    cfg_valid             <= 1'b1;
    cfg_first_line_number <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stage one lexical piece: mostly well-formed tokens with random content,
  // plus broken pairs, unterminated strings, whitespace and raw noise.
  task automatic add_piece();
    int    sel;
    string kw;
    logic  q;
    sel = $urandom_range(0, 11);
    case (sel)
      0: stage_char(pick_char("()[]:;,.#"));
      1: begin
        case ($urandom_range(0, 3))
          0:       load_text("{{");
          1:       load_text("}}");
          2:       load_text("{");
          default: load_text("}");
        endcase
      end
      2: begin
        if ($urandom_range(0, 1)) load_text("->");
        else load_text("-");
      end
      3: load_text("&->");
      4: begin
        // lone ampersand or ampersand-dash with a random follower
        load_text("&");
        if ($urandom_range(0, 1)) load_text("-");
        stage_char(pick_char("x>9- ("));
      end
      5: begin
        q = 1'($urandom_range(0, 1));
        load_text(q ? "'" : "\"");
        repeat ($urandom_range(0, 6)) stage_char(pick_char("ab \n'\"9_"));
        if ($urandom_range(0, 7) != 0) load_text(q ? "'" : "\"");
      end
      6: begin
        repeat ($urandom_range(1, 4)) stage_char(pick_char("0123456789"));
        if ($urandom_range(0, 1)) begin
          load_text(".");
          repeat ($urandom_range(0, 3)) stage_char(pick_char("0123456789"));
        end
      end
      7: begin
        stage_char(pick_char("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_"));
        repeat ($urandom_range(0, 8)) begin
          stage_char(pick_char("abcdefghijklmnopqrstuvwxyzLDA_0123456789"));
        end
      end
      8, 11: begin
        case ($urandom_range(0, 2))
          0:       kw = "Listen";
          1:       kw = "Delegate";
          default: kw = "Animate";
        endcase
        // exact word, truncated, extended, or with the last letter changed
        case ($urandom_range(0, 3))
          0: load_text(kw);
          1: load_text(kw.substr(0, kw.len() - 2));
          2: begin
            load_text(kw);
            stage_char(pick_char("s_9"));
          end
          default: begin
            load_text(kw.substr(0, kw.len() - 2));
            load_text("x");
          end
        endcase
        stage_char(pick_char(" ;(\n"));
      end
      9:       stage_char(pick_char(" \t\n"));
      default: stage_char(8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic compose_source();
    repeat ($urandom_range(1, 10)) add_piece();
  endtask

  initial begin : stimulus
    logic [15:0] line_setting;
    rst_n                 <= 1'b0;
    in_valid              <= 1'b0;
    in_word               <= '0;
    cfg_valid             <= 1'b0;
    cfg_first_line_number <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: top line number so a newline saturates; lone ampersand, ampersand-dash
    // swallowing its dash, number then dot, skipped bytes, unterminated string at the end.
    write_first_line(16'hFFFF);
    load_text("&x&-y\n7.)");
    stage_char(8'h00);
    stage_char(8'hFF);
    load_text("'ab");
    send_text(1'b1);
    settle();

    // Directed: held braces and minus flushed by the next byte, number-dot flushed at the end.
    write_first_line(16'h0000);
    load_text("{-}1.");
    send_text(1'b1);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          line_setting = LINE_RESET;
          tx_gap_max   = GAP_MAX;
          rx_gap_max   = GAP_MAX;
        end
        1: begin
          // sender at full rate against a slow sink
          line_setting = 16'($urandom_range(0, 16'hFFFF));
          tx_gap_max   = 0;
          rx_gap_max   = GAP_MAX;
        end
        2: begin
          // no idling on either side, with the one long hold-off
          line_setting  = 16'h0000;
          tx_gap_max    = 0;
          rx_gap_max    = 0;
          want_hold_off = 1'b1;
        end
        3: begin
          line_setting = 16'hFFFF;
          tx_gap_max   = GAP_MAX;
          rx_gap_max   = 0;
        end
        4: begin
          line_setting = 16'($urandom_range(0, 16'hFFFF));
          tx_gap_max   = GAP_MAX;
          rx_gap_max   = GAP_MAX;
        end
        default: begin
          line_setting = 16'($urandom_range(0, 16'hFFFF));
          tx_gap_max   = GAP_MAX;
          rx_gap_max   = GAP_MAX;
        end
      endcase
      write_first_line(line_setting);
      while (sent_bytes < RANDOM_ITEMS * (ph + 1) / PHASES) begin
        compose_source();
        send_text(1'b1);
      end
      // leave a source open so the next register write lands mid-source
      if (ph == 3) begin
        load_text("ab1");
        send_text(1'b0);
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("script_token_scanner verification clean");
    end else begin
      $display("script_token_scanner verification failed");
    end
    $finish;
  end

endmodule
